[rtl/status_field_line_encoder_macros.svh]
// Assertion macros shared by the status field line encoder.
`ifndef STATUS_FIELD_LINE_ENCODER_MACROS_SVH
`define STATUS_FIELD_LINE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sfle_pkg.sv]
// Types, constants and the static table lookup of the status field line encoder.
`default_nettype none
package sfle_pkg;

	localparam int CODE_W      = 10;
	localparam int BYTE_W      = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CODE_W-1:0] CODE_MIN     = 10'd100;
	localparam logic [CODE_W-1:0] CODE_MAX     = 10'd999;
	localparam logic [6:0]        PREFIX_FULL6 = 7'd63;

	localparam logic [BYTE_W-1:0] PAT_INDEXED   = 8'hc0;
	localparam logic [BYTE_W-1:0] IDX_FULL_BYTE = PAT_INDEXED | {1'b0, PREFIX_FULL6};
	localparam logic [BYTE_W-1:0] LIT_NAME_B0   = 8'h5f;
	localparam logic [BYTE_W-1:0] LIT_NAME_B1   = 8'h09;
	localparam logic [BYTE_W-1:0] LIT_LEN_B2    = 8'h03;
	localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'h30;
	localparam logic [BYTE_W-1:0] BAD_BYTE      = 8'h00;

	localparam logic [2:0] LIT_LAST_CNT = 3'd5;

	typedef enum logic [1:0] {
		KIND_BAD,
		KIND_IDX1,
		KIND_IDX2,
		KIND_LIT
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] tab_byte;
		logic [CODE_W-1:0] code;
		logic [3:0]        hund;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Returns the static table index of a code, or zero when it has none.
	function automatic logic [6:0] static_index(input logic [CODE_W-1:0] code);
		logic [6:0] idx;
		case (code)
			10'd103: idx = 7'd24;
			10'd200: idx = 7'd25;
			10'd304: idx = 7'd26;
			10'd404: idx = 7'd27;
			10'd503: idx = 7'd28;
			10'd100: idx = 7'd63;
			10'd204: idx = 7'd64;
			10'd206: idx = 7'd65;
			10'd302: idx = 7'd66;
			10'd400: idx = 7'd67;
			10'd403: idx = 7'd68;
			10'd421: idx = 7'd69;
			10'd425: idx = 7'd70;
			10'd500: idx = 7'd71;
			default: idx = 7'd0;
		endcase
		return idx;
	endfunction

endpackage
`default_nettype wire

[rtl/status_field_line_encoder.sv]
// A taken code goes into the queue, then the back end loads it and registers its first byte.
// Throughput: one byte per cycle while not stalled; a field line has one, two or six bytes.
// The byte sequencer in the back end sets that rate; a queued code follows with no gap.
// Reset clears the queue pointers, the sequencer and the output valid flag asynchronously.
`default_nettype none
`include "status_field_line_encoder_macros.svh"
module status_field_line_encoder #(
	parameter int QueueDepth = sfle_pkg::QUEUE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [sfle_pkg::CODE_W-1:0] status_code,
	input  wire logic                        code_valid,
	output logic                             code_stall,
	output logic [sfle_pkg::BYTE_W-1:0]      out_byte,
	output logic                             last_byte,
	output logic                             bad_code,
	output logic                             byte_valid,
	input  wire logic                        byte_stall
);
	import sfle_pkg::*;

	qstat_t qstat;
	entry_t wr_entry;
	entry_t head;
	logic   push;
	logic   pop;

	sfle_front u_front (
		.status_code (status_code),
		.code_valid  (code_valid),
		.code_stall  (code_stall),
		.qstat       (qstat),
		.push        (push),
		.entry       (wr_entry)
	);

	sfle_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	sfle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.bad_code   (bad_code),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall)
	);

	`SFLE_ASSERT_NOW(a_bad_single, clk, arst_n, byte_valid && bad_code, last_byte && (out_byte == BAD_BYTE), "Bad code word is not a single zero byte.")
	`SFLE_ASSERT_NEXT(a_line_no_gap, clk, arst_n, byte_valid && !byte_stall && !last_byte, byte_valid, "Field line has a gap between bytes.")
	`SFLE_ASSERT_NOW(a_full_prefix_cont, clk, arst_n, byte_valid && !bad_code && (out_byte == IDX_FULL_BYTE), !last_byte, "Full index prefix ends a field line.")

endmodule
`default_nettype wire

[rtl/sfle_front.sv]
// Front end: accepts status codes and classifies each into a queue entry.
`default_nettype none
module sfle_front (
	input  wire logic [sfle_pkg::CODE_W-1:0] status_code,
	input  wire logic                        code_valid,
	output logic                             code_stall,
	input  wire sfle_pkg::qstat_t            qstat,
	output logic                             push,
	output sfle_pkg::entry_t                 entry
);
	import sfle_pkg::*;

	logic [6:0]  idx;
	logic [15:0] hund_prod;
	logic        out_of_range;

	always_comb begin
		idx          = static_index(status_code);
		hund_prod    = 16'(status_code) * 16'd41;
		out_of_range = (status_code < CODE_MIN) || (status_code > CODE_MAX);

		entry.code = status_code;
		entry.hund = hund_prod[15:12];
		if (out_of_range) begin
			entry.kind     = KIND_BAD;
			entry.tab_byte = BAD_BYTE;
		end else if (idx == 7'd0) begin
			entry.kind     = KIND_LIT;
			entry.tab_byte = BAD_BYTE;
		end else if (idx < PREFIX_FULL6) begin
			entry.kind     = KIND_IDX1;
			entry.tab_byte = PAT_INDEXED | {1'b0, idx};
		end else begin
			entry.kind     = KIND_IDX2;
			entry.tab_byte = {1'b0, idx - PREFIX_FULL6};
		end

		code_stall = qstat.full;
		push       = code_valid && !qstat.full;
	end

endmodule
`default_nettype wire

[rtl/sfle_queue.sv]
// Short queue of classified words between the front and back ends.
`default_nettype none
module sfle_queue #(
	parameter int Depth = sfle_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sfle_pkg::entry_t wr_entry,
	input  wire logic             pop,
	output sfle_pkg::entry_t      head,
	output sfle_pkg::qstat_t      qstat
);
	import sfle_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	entry_t          mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	always_comb begin
		qstat.full  = (count_q == CntW'(Depth));
		qstat.empty = (count_q == '0);
		do_push     = push && !qstat.full;
		do_pop      = pop && !qstat.empty;
		head        = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule
`default_nettype wire

[rtl/sfle_back.sv]
// Back end: steps through the bytes of each field line into the output register.
`default_nettype none
module sfle_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sfle_pkg::entry_t            head,
	input  wire sfle_pkg::qstat_t            qstat,
	output logic                             pop,
	output logic [sfle_pkg::BYTE_W-1:0]      out_byte,
	output logic                             last_byte,
	output logic                             bad_code,
	output logic                             byte_valid,
	input  wire logic                        byte_stall
);
	import sfle_pkg::*;

	logic              busy_q;
	kind_t             kind_q;
	logic [2:0]        cnt_q;
	logic [BYTE_W-1:0] tab_q;
	logic [3:0]        hund_q;
	logic [6:0]        rem_q;
	logic [3:0]        tens_q;

	logic              ovalid_q;
	logic [BYTE_W-1:0] obyte_q;
	logic              olast_q;
	logic              obad_q;

	logic              adv;
	logic              cur_last;
	logic              load;
	logic [BYTE_W-1:0] cur_byte;
	logic [CODE_W-1:0] hund_x100;
	logic [CODE_W-1:0] rem_full;
	logic [14:0]       tens_prod;
	logic [6:0]        tens_x10;
	logic [6:0]        ones_full;

	always_comb begin
		hund_x100 = {head.hund, 6'b0} + {1'b0, head.hund, 5'b0} + {4'b0, head.hund, 2'b0};
		rem_full  = head.code - hund_x100;
		tens_prod = 15'(rem_q) * 15'd205;
		tens_x10  = {tens_q, 3'b0} + {2'b0, tens_q, 1'b0};
		ones_full = rem_q - tens_x10;

		case (kind_q)
			KIND_BAD:  cur_last = (cnt_q == 3'd0);
			KIND_IDX1: cur_last = (cnt_q == 3'd0);
			KIND_IDX2: cur_last = (cnt_q == 3'd1);
			KIND_LIT:  cur_last = (cnt_q == LIT_LAST_CNT);
			default:   cur_last = 1'b1;
		endcase

		case (kind_q)
			KIND_BAD:  cur_byte = BAD_BYTE;
			KIND_IDX1: cur_byte = tab_q;
			KIND_IDX2: cur_byte = (cnt_q == 3'd0) ? IDX_FULL_BYTE : tab_q;
			KIND_LIT: begin
				case (cnt_q)
					3'd0:    cur_byte = LIT_NAME_B0;
					3'd1:    cur_byte = LIT_NAME_B1;
					3'd2:    cur_byte = LIT_LEN_B2;
					3'd3:    cur_byte = ASCII_ZERO | {4'b0, hund_q};
					3'd4:    cur_byte = ASCII_ZERO | {4'b0, tens_q};
					default: cur_byte = ASCII_ZERO | {4'b0, ones_full[3:0]};
				endcase
			end
			default:   cur_byte = BAD_BYTE;
		endcase

		adv  = busy_q && (!ovalid_q || !byte_stall);
		load = !qstat.empty && (!busy_q || (adv && cur_last));
		pop  = load;

		out_byte   = obyte_q;
		last_byte  = olast_q;
		bad_code   = obad_q;
		byte_valid = ovalid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (adv) begin
				busy_q <= !cur_last;
				cnt_q  <= cnt_q + 3'd1;
			end
			if (adv) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && !byte_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tens_q <= tens_prod[14:11];
		if (load) begin
			kind_q <= head.kind;
			tab_q  <= head.tab_byte;
			hund_q <= head.hund;
			rem_q  <= rem_full[6:0];
		end
		if (adv) begin
			obyte_q <= cur_byte;
			olast_q <= cur_last;
			obad_q  <= (kind_q == KIND_BAD);
		end
	end

endmodule
`default_nettype wire

[bench/status_field_line_encoder_tb.sv]
// Self-checking testbench that encodes status codes and checks each field line byte.
`timescale 1ns / 100ps
`default_nettype none
module status_field_line_encoder_tb;
	import sfle_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CODES = 420;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int END_WAIT_CYCLES = 20;

	localparam int CODE_LOW = 100;
	localparam int CODE_HIGH = 999;
	localparam int PREFIX6_FULL = 63;
	localparam logic [BYTE_W-1:0] INDEXED_PAT = 8'hc0;
	localparam logic [BYTE_W-1:0] LIT_NAME_HEAD = 8'h5f;
	localparam logic [BYTE_W-1:0] LIT_NAME_REST = 8'h09;
	localparam logic [BYTE_W-1:0] LIT_VALUE_LEN = 8'h03;
	localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] FLAGGED_BYTE = 8'h00;

	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              last;
		logic              bad;
	} field_byte_t;

	typedef struct {
		logic [CODE_W-1:0] code;
		bit                drain_first;
	} code_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [CODE_W-1:0] status_code = '0;
	logic              code_valid = 1'b0;
	logic              code_stall;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;
	logic              bad_code;
	logic              byte_valid;
	logic              byte_stall = 1'b0;

	field_byte_t pending_bytes[$];
	code_item_t  code_queue[$];
	int          table_codes[14] = '{103, 200, 304, 404, 503,
		100, 204, 206, 302, 400, 403, 421, 425, 500};

	int error_count = 0;
	int cycle_count = 0;
	int codes_taken = 0;
	int burst_left = 0;
	int gap_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	status_field_line_encoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.status_code(status_code),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.bad_code   (bad_code),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic int lookup_index(input logic [CODE_W-1:0] code);
		int idx;
		idx = 0;
		for (int k = 0; k < 14; k++) begin
			if (table_codes[k] == code) begin
				idx = (k < 5) ? 24 + k : 58 + k;
			end
		end
		return idx;
	endfunction

	function automatic void add_byte(input logic [BYTE_W-1:0] value, input logic last,
		input logic bad);
		field_byte_t fb;
		fb.value = value;
		fb.last = last;
		fb.bad = bad;
		pending_bytes.push_back(fb);
	endfunction

	function automatic void encode_field_line(input logic [CODE_W-1:0] code);
		int c;
		int idx;
		c = code;
		idx = lookup_index(code);
		if (c < CODE_LOW || c > CODE_HIGH) begin
			add_byte(FLAGGED_BYTE, 1'b1, 1'b1);
		end else if (idx != 0) begin
			if (idx < PREFIX6_FULL) begin
				add_byte(INDEXED_PAT | BYTE_W'(idx), 1'b1, 1'b0);
			end else begin
				add_byte(INDEXED_PAT | BYTE_W'(PREFIX6_FULL), 1'b0, 1'b0);
				add_byte(BYTE_W'(idx - PREFIX6_FULL), 1'b1, 1'b0);
			end
		end else begin
			add_byte(LIT_NAME_HEAD, 1'b0, 1'b0);
			add_byte(LIT_NAME_REST, 1'b0, 1'b0);
			add_byte(LIT_VALUE_LEN, 1'b0, 1'b0);
			add_byte(DIGIT_ZERO + BYTE_W'(c / 100), 1'b0, 1'b0);
			add_byte(DIGIT_ZERO + BYTE_W'((c / 10) % 10), 1'b0, 1'b0);
			add_byte(DIGIT_ZERO + BYTE_W'(c % 10), 1'b1, 1'b0);
		end
	endfunction

	always @(posedge clk) begin
		logic              next_valid;
		logic [CODE_W-1:0] next_code;
		code_item_t        next_item;
		next_valid = code_valid;
		next_code = status_code;
		if (arst_n) begin
			if (code_valid && !code_stall) begin
				encode_field_line(status_code);
				codes_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (code_queue.size() > 0 &&
					!(code_queue[0].drain_first && pending_bytes.size() > 0)) begin
					next_valid = 1'b1;
					next_item = code_queue.pop_front();
					next_code = next_item.code;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
						gap_left = $urandom_range(1, 6);
					end
				end
			end
		end
		code_valid <= next_valid;
		status_code <= next_code;
	end

	always @(posedge clk) begin
		logic next_stall;
		rx_cycle++;
		if (rx_cycle % 50 == 0) begin
			rx_mode = $urandom_range(0, 3);
		end
		if (!hold_done && codes_taken >= 150) begin
			hold_done = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			next_stall = 1'b1;
		end else begin
			case (rx_mode)
				0: next_stall = 1'b0;
				1: next_stall = 1'($urandom_range(0, 1));
				2: next_stall = ($urandom_range(0, 3) != 0);
				default: next_stall = (rx_cycle % 3 == 0);
			endcase
		end
		byte_stall <= next_stall;
	end

	always @(posedge clk) begin
		field_byte_t want;
		if (arst_n && byte_valid && !byte_stall) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected word", out_byte, 0);
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.value) begin
					report_mismatch("out_byte", out_byte, want.value);
				end
				if (last_byte !== want.last) begin
					report_mismatch("last_byte", last_byte, want.last);
				end
				if (bad_code !== want.bad) begin
					report_mismatch("bad_code", bad_code, want.bad);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int directed[22] = '{0, 99, 100, 103, 200, 204, 206, 302, 304, 400, 403, 404,
			421, 425, 500, 503, 101, 999, 1000, 1023, 512, 255};
		code_item_t item;
		int pick;
		for (int k = 0; k < 22; k++) begin
			item.code = CODE_W'(directed[k]);
			item.drain_first = 1'b0;
			code_queue.push_back(item);
		end
		for (int k = 0; k < RANDOM_CODES; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				item.code = CODE_W'(table_codes[$urandom_range(0, 13)]);
			end else if (pick < 25) begin
				item.code = CODE_W'($urandom_range(0, CODE_LOW - 1));
			end else if (pick < 30) begin
				item.code = CODE_W'($urandom_range(CODE_HIGH + 1, 1023));
			end else if (pick < 40) begin
				item.code = CODE_W'($urandom_range(0, 1023));
			end else begin
				item.code = CODE_W'($urandom_range(CODE_LOW, CODE_HIGH));
			end
			item.drain_first = (k == 0 || k == 300);
			code_queue.push_back(item);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (code_queue.size() > 0 || code_valid || pending_bytes.size() > 0) begin
			@(posedge clk);
		end
		repeat (END_WAIT_CYCLES) @(posedge clk);
		if (pending_bytes.size() > 0) begin
			report_mismatch("words never seen", 0, pending_bytes.size());
		end
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/sfle_pkg.sv
rtl/sfle_front.sv
rtl/sfle_queue.sv
rtl/sfle_back.sv
rtl/status_field_line_encoder.sv
bench/status_field_line_encoder_tb.sv
